// ===== design/spta_pkg.sv =====
// Shared constants, codes and types of the sparse polynomial term accumulator.
package spta_pkg;

    localparam int MAX_TERMS = 64;
    localparam int EXPO_BITS = 10;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int SUM_W     = 32 + CNT_W;
    localparam int ENTRY_W   = 32 + EXPO_BITS;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_SUB   = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_EVAL  = 3'd4;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FULL  = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CHK, S_DEL_RD, S_DEL_WR, S_INS_RD,
        S_INS_WR, S_READ_WAIT, S_EV_RD, S_EV_MUL, S_EV_STEP, S_EV_ADD, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR, OP_SET_EMPTY, OP_RD_POS, OP_CAPT_READ,
        OP_RD_IDX, OP_IDX_INC, OP_SET_FULL, OP_INS_INIT, OP_MERGE_WR, OP_DEL_INIT,
        OP_RD_J1, OP_WR_J_INC, OP_CNT_DEC, OP_RD_JM1, OP_WR_J_DEC, OP_INS_WR,
        OP_EV_INIT, OP_EV_RD, OP_MUL_PX, OP_MUL_CP, OP_POW_NEXT, OP_ACC,
        OP_EV_FIN, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       coef_zero;
        logic       pos_lt_cnt;
        logic       idx_lt_cnt;
        logic       full;
        logic       rexp_gt;
        logic       rexp_eq;
        logic       merge_zero;
        logic       j1_lt_cnt;
        logic       j_gt_idx;
        logic       k_lt_e;
        logic       pow_fixed;
    } dp_stat_t;

endpackage

// ===== design/spta_if.sv =====
// Request and response channel interfaces of the term accumulator.
interface spta_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] coefficient;
    logic [9:0]         exponent;
    logic [5:0]         position;
    logic signed [31:0] point_x;

    modport source (output valid, command, coefficient, exponent, position, point_x,
                    input ready);
    modport sink (input valid, command, coefficient, exponent, position, point_x,
                  output ready);
endinterface

interface spta_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [6:0]         term_count;
    logic signed [31:0] read_coefficient;
    logic [9:0]         read_exponent;
    logic signed [31:0] value;
    logic               saturated;

    modport source (output valid, status, term_count, read_coefficient, read_exponent,
                    value, saturated, input ready);
    modport sink (input valid, status, term_count, read_coefficient, read_exponent,
                  value, saturated, output ready);
endinterface

// ===== design/spta_datapath.sv =====
// Datapath: term memory, search and shift pointers, shared multiplier and accumulator.
module spta_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  spta_pkg::dp_op_t    op,
    input  logic [2:0]          command,
    input  logic signed [31:0]  coefficient,
    input  logic [9:0]          exponent,
    input  logic [5:0]          position,
    input  logic signed [31:0]  point_x,
    output spta_pkg::dp_stat_t  stat,
    output logic [1:0]          status,
    output logic [6:0]          term_count,
    output logic signed [31:0]  read_coefficient,
    output logic [9:0]          read_exponent,
    output logic signed [31:0]  value,
    output logic                saturated
);
    import spta_pkg::*;

    logic [ENTRY_W-1:0]   mem [MAX_TERMS];
    logic [ENTRY_W-1:0]   rdata_reg;
    logic [2:0]           cmd_reg;
    logic signed [31:0]   coef_reg;
    logic [EXPO_BITS-1:0] expo_reg;
    logic [5:0]           pos_reg;
    logic signed [31:0]   x_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [EXPO_BITS-1:0] k_reg;
    logic signed [31:0]   pow_reg;
    logic signed [63:0]   prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [1:0]           res_reg;
    logic                 sat_reg;
    logic signed [31:0]   rc_reg;
    logic [EXPO_BITS-1:0] re_reg;
    logic signed [31:0]   val_reg;
    logic [1:0]           status_reg;
    logic [6:0]           term_count_reg;
    logic signed [31:0]   read_coefficient_reg;
    logic [9:0]           read_exponent_reg;
    logic signed [31:0]   value_reg;
    logic                 saturated_reg;

    logic signed [31:0]   rd_coef;
    logic [EXPO_BITS-1:0] rd_expo;
    logic signed [63:0]   prod_rnd;
    logic                 qm_ovf;
    logic signed [31:0]   qm_val;
    logic signed [32:0]   merge_sum;
    logic                 merge_ovf;
    logic signed [31:0]   merge_val;
    logic                 sum_ovf;
    logic signed [31:0]   sum_val;
    logic [CNT_W-1:0]     j_inc;
    logic [CNT_W-1:0]     j_dec;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    assign rd_coef = signed'(rdata_reg[ENTRY_W-1 -: 32]);
    assign rd_expo = rdata_reg[EXPO_BITS-1:0];
    assign j_inc   = j_reg + CNT_W'(1);
    assign j_dec   = j_reg - CNT_W'(1);

    // Q16.16 product rounded half up, then saturated.
    assign prod_rnd = (prod_reg + 64'sd32768) >>> 16;
    assign qm_ovf   = (prod_rnd > 64'(S32_MAX)) || (prod_rnd < 64'(S32_MIN));
    always_comb
    begin
        if (prod_rnd > 64'(S32_MAX))
            qm_val = S32_MAX;
        else if (prod_rnd < 64'(S32_MIN))
            qm_val = S32_MIN;
        else
            qm_val = prod_rnd[31:0];
    end

    assign merge_sum = 33'(rd_coef) + 33'(coef_reg);
    assign merge_ovf = (merge_sum > 33'(S32_MAX)) || (merge_sum < 33'(S32_MIN));
    always_comb
    begin
        if (merge_sum > 33'(S32_MAX))
            merge_val = S32_MAX;
        else if (merge_sum < 33'(S32_MIN))
            merge_val = S32_MIN;
        else
            merge_val = merge_sum[31:0];
    end

    assign sum_ovf = (sum_reg > SUM_W'(S32_MAX)) || (sum_reg < SUM_W'(S32_MIN));
    always_comb
    begin
        if (sum_reg > SUM_W'(S32_MAX))
            sum_val = S32_MAX;
        else if (sum_reg < SUM_W'(S32_MIN))
            sum_val = S32_MIN;
        else
            sum_val = sum_reg[31:0];
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = idx_reg[ADDR_W-1:0];
        unique case (op)
            OP_RD_POS:          rd_addr = ADDR_W'(pos_reg);
            OP_RD_IDX, OP_EV_RD: rd_addr = idx_reg[ADDR_W-1:0];
            OP_RD_J1:           rd_addr = j_inc[ADDR_W-1:0];
            OP_RD_JM1:          rd_addr = j_dec[ADDR_W-1:0];
            default:            rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[ADDR_W-1:0];
        wr_data = {coef_reg, expo_reg};
        unique case (op)
            OP_MERGE_WR:              wr_data = {merge_val, expo_reg};
            OP_INS_WR:                wr_data = {coef_reg, expo_reg};
            OP_WR_J_INC, OP_WR_J_DEC:
            begin
                wr_addr = j_reg[ADDR_W-1:0];
                wr_data = rdata_reg;
            end
            default:                  wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (op == OP_CLEAR)
            cnt_reg <= '0;
        else if (op == OP_CNT_DEC)
            cnt_reg <= cnt_reg - CNT_W'(1);
        else if (op == OP_INS_WR)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg  <= command;
                expo_reg <= EXPO_BITS'(exponent);
                pos_reg  <= position;
                x_reg    <= point_x;
                idx_reg  <= '0;
                res_reg  <= RES_OK;
                rc_reg   <= '0;
                re_reg   <= '0;
                val_reg  <= '0;
                if (command == CMD_SUB)
                begin
                    coef_reg <= (coefficient == S32_MIN) ? S32_MAX : -coefficient;
                    sat_reg  <= (coefficient == S32_MIN);
                end
                else
                begin
                    coef_reg <= coefficient;
                    sat_reg  <= 1'b0;
                end
            end
            OP_SET_EMPTY: res_reg <= RES_EMPTY;
            OP_SET_FULL:  res_reg <= RES_FULL;
            OP_CAPT_READ:
            begin
                rc_reg <= rd_coef;
                re_reg <= rd_expo;
            end
            OP_IDX_INC:   idx_reg <= idx_reg + CNT_W'(1);
            OP_INS_INIT:  j_reg   <= cnt_reg;
            OP_MERGE_WR:  sat_reg <= sat_reg | merge_ovf;
            OP_DEL_INIT:
            begin
                j_reg   <= idx_reg;
                sat_reg <= sat_reg | merge_ovf;
            end
            OP_WR_J_INC:  j_reg <= j_inc;
            OP_WR_J_DEC:  j_reg <= j_dec;
            OP_EV_INIT:
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            OP_EV_RD:
            begin
                pow_reg <= Q_ONE;
                k_reg   <= '0;
            end
            OP_MUL_PX:    prod_reg <= 64'(pow_reg) * 64'(x_reg);
            OP_MUL_CP:    prod_reg <= 64'(rd_coef) * 64'(pow_reg);
            OP_POW_NEXT:
            begin
                pow_reg <= qm_val;
                k_reg   <= k_reg + EXPO_BITS'(1);
                sat_reg <= sat_reg | qm_ovf;
            end
            OP_ACC:
            begin
                sum_reg <= sum_reg + SUM_W'(qm_val);
                sat_reg <= sat_reg | qm_ovf;
                idx_reg <= idx_reg + CNT_W'(1);
            end
            OP_EV_FIN:
            begin
                val_reg <= sum_val;
                sat_reg <= sat_reg | sum_ovf;
            end
            OP_EMIT:
            begin
                status_reg           <= res_reg;
                term_count_reg       <= 7'(cnt_reg);
                read_coefficient_reg <= rc_reg;
                read_exponent_reg    <= 10'(re_reg);
                value_reg            <= val_reg;
                saturated_reg        <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.cmd        = cmd_reg;
    assign stat.coef_zero  = (coef_reg == 32'sd0);
    assign stat.pos_lt_cnt = (32'(pos_reg) < 32'(cnt_reg));
    assign stat.idx_lt_cnt = (idx_reg < cnt_reg);
    assign stat.full       = (cnt_reg >= CNT_W'(MAX_TERMS));
    assign stat.rexp_gt    = (rd_expo > expo_reg);
    assign stat.rexp_eq    = (rd_expo == expo_reg);
    assign stat.merge_zero = (merge_val == 32'sd0);
    assign stat.j1_lt_cnt  = (j_inc < cnt_reg);
    assign stat.j_gt_idx   = (j_reg > idx_reg);
    assign stat.k_lt_e     = (k_reg < rd_expo);
    assign stat.pow_fixed  = (qm_val == pow_reg) && !qm_ovf;

    assign status           = status_reg;
    assign term_count       = term_count_reg;
    assign read_coefficient = read_coefficient_reg;
    assign read_exponent    = read_exponent_reg;
    assign value            = value_reg;
    assign saturated        = saturated_reg;

endmodule

// ===== design/spta_controller.sv =====
// Controller: sequences each command through the datapath and owns the handshakes.
module spta_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  spta_pkg::dp_stat_t  stat,
    output spta_pkg::dp_op_t    op
);
    import spta_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                priority if (stat.cmd == CMD_ADD || stat.cmd == CMD_SUB)
                    state_next = stat.coef_zero ? S_DONE : S_SRCH_RD;
                else if (stat.cmd == CMD_READ)
                    state_next = stat.pos_lt_cnt ? S_READ_WAIT : S_DONE;
                else if (stat.cmd == CMD_EVAL)
                    state_next = S_EV_RD;
                else
                    state_next = S_DONE;
            end
            S_SRCH_RD:
                priority if (stat.idx_lt_cnt)
                    state_next = S_SRCH_CHK;
                else if (stat.full)
                    state_next = S_DONE;
                else
                    state_next = S_INS_RD;
            S_SRCH_CHK:
                priority if (stat.rexp_gt)
                    state_next = S_SRCH_RD;
                else if (stat.rexp_eq)
                    state_next = stat.merge_zero ? S_DEL_RD : S_DONE;
                else if (stat.full)
                    state_next = S_DONE;
                else
                    state_next = S_INS_RD;
            S_DEL_RD:    state_next = stat.j1_lt_cnt ? S_DEL_WR : S_DONE;
            S_DEL_WR:    state_next = S_DEL_RD;
            S_INS_RD:    state_next = stat.j_gt_idx ? S_INS_WR : S_DONE;
            S_INS_WR:    state_next = S_INS_RD;
            S_READ_WAIT: state_next = S_DONE;
            S_EV_RD:     state_next = stat.idx_lt_cnt ? S_EV_MUL : S_DONE;
            S_EV_MUL:    state_next = stat.k_lt_e ? S_EV_STEP : S_EV_ADD;
            S_EV_STEP:   state_next = stat.pow_fixed ? S_EV_ADD : S_EV_MUL;
            S_EV_ADD:    state_next = S_EV_RD;
            S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    op = OP_LOAD;
            S_DECODE:
            begin
                priority if (stat.cmd == CMD_CLEAR)
                    op = OP_CLEAR;
                else if (stat.cmd == CMD_READ)
                    op = stat.pos_lt_cnt ? OP_RD_POS : OP_SET_EMPTY;
                else if (stat.cmd == CMD_EVAL)
                    op = OP_EV_INIT;
                else
                    op = OP_NONE;
            end
            S_SRCH_RD:
                priority if (stat.idx_lt_cnt)
                    op = OP_RD_IDX;
                else if (stat.full)
                    op = OP_SET_FULL;
                else
                    op = OP_INS_INIT;
            S_SRCH_CHK:
                priority if (stat.rexp_gt)
                    op = OP_IDX_INC;
                else if (stat.rexp_eq)
                    op = stat.merge_zero ? OP_DEL_INIT : OP_MERGE_WR;
                else if (stat.full)
                    op = OP_SET_FULL;
                else
                    op = OP_INS_INIT;
            S_DEL_RD:    op = stat.j1_lt_cnt ? OP_RD_J1 : OP_CNT_DEC;
            S_DEL_WR:    op = OP_WR_J_INC;
            S_INS_RD:    op = stat.j_gt_idx ? OP_RD_JM1 : OP_INS_WR;
            S_INS_WR:    op = OP_WR_J_DEC;
            S_READ_WAIT: op = OP_CAPT_READ;
            S_EV_RD:     op = stat.idx_lt_cnt ? OP_EV_RD : OP_EV_FIN;
            S_EV_MUL:    op = stat.k_lt_e ? OP_MUL_PX : OP_MUL_CP;
            S_EV_STEP:   op = stat.pow_fixed ? OP_MUL_CP : OP_POW_NEXT;
            S_EV_ADD:    op = OP_ACC;
            S_DONE:
                if (!out_valid_reg || out_ready)
                    op = OP_EMIT;
            default:     op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (op == OP_EMIT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted word did not enter decode");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwrote a word still waiting");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("response valid raised outside completion");

endmodule

// ===== design/sparse_poly_term_accumulator.sv =====
// Top level of the sparse polynomial term accumulator.
// The req channel takes one command word: clear, add term, subtract term, read
// term or evaluate, with its coefficient, exponent, position and point x fields.
// The rsp channel returns exactly one word per command, in order, carrying the
// status, the term count afterwards, the read term, the value and the flag.
// Terms sit in a 64-entry memory sorted by descending exponent; one entry is
// read or written per cycle, so the memory port sets the latency.
// One command is worked on at a time; the next word is accepted in the cycle
// after the previous response has been loaded into the output register.
// Clear, read and the ignored cases need no search; add or subtract first
// search entry by entry, then shift the entries behind the slot up or down.
// Evaluation reads each term and steps its power of x on the shared
// multiplier; a power stops early once it no longer changes.
// A new word is accepted while the previous response still waits, but the
// next response is held in its completion state until the receiver takes it.
// Reset empties the table; the memory contents are left as they are.
module sparse_poly_term_accumulator (
    input logic     clk,
    input logic     rst_n,
    spta_req_if.sink   req,
    spta_rsp_if.source rsp
);
    import spta_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    spta_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .op        (op)
    );

    spta_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .command          (req.command),
        .coefficient      (req.coefficient),
        .exponent         (req.exponent),
        .position         (req.position),
        .point_x          (req.point_x),
        .stat             (stat),
        .status           (rsp.status),
        .term_count       (rsp.term_count),
        .read_coefficient (rsp.read_coefficient),
        .read_exponent    (rsp.read_exponent),
        .value            (rsp.value),
        .saturated        (rsp.saturated)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for the sparse polynomial term accumulator: directed and random words checked against a term-table predictor.
`timescale 1ns / 1ps

module tb;
    import spta_pkg::*;

    localparam int IDLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]         status;
        logic [6:0]         term_count;
        logic signed [31:0] read_coefficient;
        logic [9:0]         read_exponent;
        logic signed [31:0] value;
        logic               saturated;
    } rsp_word_t;

    class term_table_model;
        int          coefs[MAX_TERMS];
        int unsigned expos[MAX_TERMS];
        int unsigned count;
        rsp_word_t   awaited[$];
        int          errors;
        int          checked;

        function int sat32(longint v, inout bit flag);
            if (v > longint'(S32_MAX)) begin flag = 1; return S32_MAX; end
            if (v < longint'(S32_MIN)) begin flag = 1; return S32_MIN; end
            return int'(v);
        endfunction

        function int qmul(int a, int b, inout bit flag);
            longint p;
            p = longint'(a) * longint'(b) + 64'sd32768;
            return sat32(p >>> 16, flag);
        endfunction

        function logic [1:0] merge_term(longint c, int unsigned e, inout bit flag);
            int unsigned i;
            int m;
            i = 0;
            if (c == 0) return RES_OK;
            while (i < count && expos[i] > e) i++;
            if (i < count && expos[i] == e) begin
                m = sat32(longint'(coefs[i]) + c, flag);
                if (m == 0) begin
                    for (int j = i; j + 1 < count; j++) begin
                        coefs[j] = coefs[j + 1];
                        expos[j] = expos[j + 1];
                    end
                    count--;
                end else begin
                    coefs[i] = m;
                end
                return RES_OK;
            end
            if (count >= MAX_TERMS) return RES_FULL;
            for (int j = count; j > i; j--) begin
                coefs[j] = coefs[j - 1];
                expos[j] = expos[j - 1];
            end
            coefs[i] = int'(c);
            expos[i] = e;
            count++;
            return RES_OK;
        endfunction

        function int evaluate(int x, inout bit flag);
            longint sum;
            int p;
            int n;
            bit f;
            sum = 0;
            for (int t = 0; t < count; t++) begin
                p = Q_ONE;
                for (int k = 0; k < expos[t]; k++) begin
                    f = 0;
                    n = qmul(p, x, f);
                    if (f) flag = 1;
                    if (n == p && !f) break;
                    p = n;
                end
                sum += longint'(qmul(coefs[t], p, flag));
            end
            return sat32(sum, flag);
        endfunction

        function void note_request(logic [2:0] cmd, logic signed [31:0] coef,
                                   logic [9:0] expo, logic [5:0] pos,
                                   logic signed [31:0] x);
            rsp_word_t w;
            bit sat;
            int negc;
            sat = 0;
            w = '{default: '0};
            case (cmd)
                CMD_CLEAR: count = 0;
                CMD_ADD:   w.status = merge_term(longint'(coef), expo, sat);
                CMD_SUB:
                begin
                    negc = sat32(-longint'(coef), sat);
                    w.status = merge_term(longint'(negc), expo, sat);
                end
                CMD_READ:
                begin
                    if (pos < count) begin
                        w.read_coefficient = coefs[pos];
                        w.read_exponent = expos[pos];
                    end else begin
                        w.status = RES_EMPTY;
                    end
                end
                CMD_EVAL:  w.value = evaluate(x, sat);
                default: ;
            endcase
            w.term_count = count[6:0];
            w.saturated = sat;
            awaited.push_back(w);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_response(rsp_word_t got);
            rsp_word_t w;
            checked++;
            if (awaited.size() == 0) begin
                report("unexpected response word", 0, 0);
                return;
            end
            w = awaited.pop_front();
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.term_count !== w.term_count)
                report("term_count", got.term_count, w.term_count);
            if (got.read_coefficient !== w.read_coefficient)
                report("read_coefficient", got.read_coefficient, w.read_coefficient);
            if (got.read_exponent !== w.read_exponent)
                report("read_exponent", got.read_exponent, w.read_exponent);
            if (got.value !== w.value) report("value", got.value, w.value);
            if (got.saturated !== w.saturated) report("saturated", got.saturated, w.saturated);
        endtask
    endclass

    logic clk;
    logic rst_n;
    spta_req_if req ();
    spta_rsp_if rsp ();
    term_table_model table_model;
    int idle_cycles;
    int cyc;
    int n_evals;
    int n_full;

    sparse_poly_term_accumulator u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_word_t got;
        if (req.valid && req.ready)
            table_model.note_request(req.command, req.coefficient, req.exponent,
                                     req.position, req.point_x);
        if (rsp.valid && rsp.ready) begin
            got.status = rsp.status;
            got.term_count = rsp.term_count;
            got.read_coefficient = rsp.read_coefficient;
            got.read_exponent = rsp.read_exponent;
            got.value = rsp.value;
            got.saturated = rsp.saturated;
            table_model.check_response(got);
        end
    end

    // The receiver stalls in its own phases: some always ready, some sparse.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc >> 8) % 4)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ((cyc % 7) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding",
                     table_model.awaited.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    int burst_left;

    task send_word(logic [2:0] cmd, logic signed [31:0] coef, logic [9:0] expo,
                   logic [5:0] pos, logic signed [31:0] x);
        req.valid       <= 1'b1;
        req.command     <= cmd;
        req.coefficient <= coef;
        req.exponent    <= expo;
        req.position    <= pos;
        req.point_x     <= x;
        if (cmd == CMD_EVAL) n_evals++;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task drain;
        req.valid <= 1'b0;
        @(posedge clk);
        while (table_model.awaited.size() != 0) @(posedge clk);
    endtask

    task random_word;
        logic [2:0] cmd;
        logic [9:0] expo;
        logic signed [31:0] coef;
        logic signed [31:0] x;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) cmd = CMD_CLEAR;
        else if (r < 42) cmd = CMD_ADD;
        else if (r < 62) cmd = CMD_SUB;
        else if (r < 84) cmd = CMD_READ;
        else if (r < 96) cmd = CMD_EVAL;
        else cmd = 3'($urandom_range(5, 7));
        expo = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       coef = $urandom;
            1:       coef = ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
            2:       coef = 0;
            default: coef = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
        endcase
        case ($urandom_range(0, 7))
            0:       x = $urandom;
            1:       x = -Q_ONE;
            2:       x = Q_ONE;
            default: x = $signed($urandom_range(0, 32'h1_FFFF)) - 32'sh1_0000;
        endcase
        if (table_model.count >= MAX_TERMS) n_full++;
        send_word(cmd, coef, expo, 6'($urandom), x);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cyc = 0;
        idle_cycles = 0;
        n_evals = 0;
        n_full = 0;
        burst_left = 0;
        table_model = new();
        req.valid = 0;
        req.command = CMD_CLEAR;
        req.coefficient = 0;
        req.exponent = 0;
        req.position = 0;
        req.point_x = 0;
        rsp.ready = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_READ, 0, 0, 0, 0);
        send_word(CMD_EVAL, 0, 0, 0, Q_ONE);
        send_word(CMD_ADD, S32_MAX, 10'h3FF, 0, 0);
        send_word(CMD_ADD, S32_MIN, 0, 0, 0);
        send_word(CMD_ADD, 0, 5, 0, 0);
        send_word(CMD_SUB, S32_MIN, 7, 0, 0);
        send_word(CMD_ADD, 100, 10'h3FF, 0, 0);
        send_word(CMD_SUB, S32_MAX, 10'h3FF, 0, 0);
        send_word(CMD_SUB, S32_MAX, 7, 0, 0);
        send_word(CMD_READ, 0, 0, 6'd63, 0);
        send_word(CMD_READ, 0, 0, 6'd1, 0);
        send_word(3'd5, 1, 1, 0, 0);
        send_word(3'd6, 1, 1, 0, 0);
        send_word(3'd7, 1, 1, 0, 0);
        send_word(CMD_EVAL, 0, 0, 0, -Q_ONE);
        send_word(CMD_EVAL, 0, 0, 0, S32_MAX);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_TERMS; i++)
            send_word(CMD_ADD, $urandom, 10'(i * 16 + 15), 0, 0);
        send_word(CMD_ADD, Q_ONE, 10'd2, 0, 0);
        send_word(CMD_ADD, Q_ONE, 10'd15, 0, 0);
        send_word(CMD_READ, 0, 0, 6'd63, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'sh0000_8000);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        drain();

        for (int i = 0; i < 800; i++) begin
            if (i == 400) drain();
            random_word();
        end

        drain();
        repeat (300) @(posedge clk);
        $display("Covered %0d response words, %0d evaluations, %0d words sent at a full table.",
                 table_model.checked, n_evals, n_full);
        if (table_model.errors == 0 && table_model.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
